/* rtl/core/asd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asd_pkg - shared types and constants of the auto-ranging segment drive
// Range codes, rounding and reciprocal constants, segment table and the
// request types that travel between the pipeline sections.
// ----------------------------------------------------------------------------
package asd_pkg;

  localparam int unsigned VALUE_W   = 24;
  localparam int unsigned SUM_W     = VALUE_W + 1;
  localparam int unsigned QUOT_W    = 15;
  localparam int unsigned NUM_W     = 14;
  localparam int unsigned RECIP_W   = 32;
  localparam int unsigned PROD_W    = SUM_W + RECIP_W;
  localparam int unsigned RECIP_SH  = 35;
  localparam int unsigned Q0_W      = PROD_W - RECIP_SH;
  localparam int unsigned DIGITS    = 4;
  localparam int unsigned SEG_W     = 7;

  // number of decimal places shown
  typedef logic [1:0] places_t;
  localparam places_t PLACES_0 = 2'd0;
  localparam places_t PLACES_1 = 2'd1;
  localparam places_t PLACES_2 = 2'd2;
  localparam places_t PLACES_3 = 2'd3;

  localparam logic [VALUE_W-1:0] LIMIT_3 = 24'd10000;
  localparam logic [VALUE_W-1:0] LIMIT_2 = 24'd100000;
  localparam logic [VALUE_W-1:0] LIMIT_1 = 24'd1000000;
  localparam logic [QUOT_W-1:0]  WRAP    = 15'd10000;

  typedef struct packed {
    logic [QUOT_W-1:0] q;
    places_t           places;
  } quot_t;

  typedef struct packed {
    logic [DIGITS-1:0][SEG_W-1:0] seg;
    logic [DIGITS-1:0]            dp_mask;
  } disp_t;

  // half of the dropped unit, added before truncation
  function automatic logic [9:0] round_add(places_t p);
    logic [9:0] r;
    unique case (p)
      PLACES_3: r = 10'd0;
      PLACES_2: r = 10'd5;
      PLACES_1: r = 10'd50;
      PLACES_0: r = 10'd500;
      default:  r = 10'd0;
    endcase
    return r;
  endfunction

  function automatic logic [9:0] divisor(places_t p);
    logic [9:0] d;
    unique case (p)
      PLACES_3: d = 10'd1;
      PLACES_2: d = 10'd10;
      PLACES_1: d = 10'd100;
      PLACES_0: d = 10'd1000;
      default:  d = 10'd1;
    endcase
    return d;
  endfunction

  // floor(2^35 / divisor), 0 for divisor 1; quotient estimate low by at most one
  function automatic logic [RECIP_W-1:0] recip(places_t p);
    logic [RECIP_W-1:0] m;
    unique case (p)
      PLACES_3: m = 32'd0;
      PLACES_2: m = 32'd3435973836;
      PLACES_1: m = 32'd343597383;
      PLACES_0: m = 32'd34359738;
      default:  m = 32'd0;
    endcase
    return m;
  endfunction

  // largest k in 0..9 with k * unit <= val
  function automatic logic [3:0] digit_of(logic [NUM_W-1:0] val, logic [9:0] unit);
    logic [3:0] d;
    d = 4'd0;
    for (int k = 1; k <= 9; k++) begin
      if ({18'd0, val} >= 32'(k) * {22'd0, unit}) d = 4'(k);
    end
    return d;
  endfunction

  // bit0 = a .. bit6 = g
  function automatic logic [SEG_W-1:0] seg_code(logic [3:0] d);
    logic [SEG_W-1:0] s;
    unique case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

  // point on digit index 3 - places, none with zero places
  function automatic logic [DIGITS-1:0] dp_of(places_t p);
    logic [DIGITS-1:0] m;
    unique case (p)
      PLACES_3: m = 4'b0001;
      PLACES_2: m = 4'b0010;
      PLACES_1: m = 4'b0100;
      PLACES_0: m = 4'b0000;
      default:  m = 4'b0000;
    endcase
    return m;
  endfunction

endpackage

/* rtl/core/asd_range_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asd_range_div - range select, rounding and scaling division
// Three stages: pick places and add the rounding half, multiply by the
// reciprocal of the divisor, then correct the quotient estimate.
// ----------------------------------------------------------------------------
module asd_range_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [asd_pkg::VALUE_W-1:0]   in_value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output asd_pkg::quot_t                out_item
);
  import asd_pkg::*;

  logic               v1_r, v2_r, v3_r;
  logic               s1, s2, s3;
  places_t            pl_nxt, pl1_r, pl2_r;
  logic [SUM_W-1:0]   sum_nxt, sum1_r, sum2_r;
  logic [PROD_W-1:0]  prod2_r;
  logic [Q0_W-1:0]    q0;
  logic [31:0]        qd;
  logic [31:0]        rem;
  logic [9:0]         div2;
  logic [Q0_W-1:0]    qc;
  quot_t              item_nxt, item3_r;

  // stall ripples back from the output through occupied stages
  assign s3       = v3_r & out_stall;
  assign s2       = v2_r & s3;
  assign s1       = v1_r & s2;
  assign in_stall = s1;

  always_comb begin
    priority if (in_value < LIMIT_3) pl_nxt = PLACES_3;
    else if (in_value < LIMIT_2)     pl_nxt = PLACES_2;
    else if (in_value < LIMIT_1)     pl_nxt = PLACES_1;
    else                             pl_nxt = PLACES_0;
    sum_nxt = {1'b0, in_value} + {15'd0, round_add(pl_nxt)};
  end

  always_comb begin
    div2 = divisor(pl2_r);
    q0   = prod2_r[PROD_W-1:RECIP_SH];
    qd   = {10'd0, q0} * {22'd0, div2};
    rem  = {7'd0, sum2_r} - qd;
    qc   = (rem >= {22'd0, div2}) ? q0 + 1'b1 : q0;
    item_nxt.places = pl2_r;
    item_nxt.q      = (pl2_r == PLACES_3) ? sum2_r[QUOT_W-1:0] : qc[QUOT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (!s1) v1_r <= in_valid;
      if (!s2) v2_r <= v1_r;
      if (!s3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!s1) begin
      sum1_r <= sum_nxt;
      pl1_r  <= pl_nxt;
    end
    if (!s2) begin
      prod2_r <= {{RECIP_W{1'b0}}, sum1_r} * {{SUM_W{1'b0}}, recip(pl1_r)};
      sum2_r  <= sum1_r;
      pl2_r   <= pl1_r;
    end
    if (!s3) item3_r <= item_nxt;
  end

  assign out_valid = v3_r;
  assign out_item  = item3_r;

endmodule

/* rtl/core/asd_digits.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asd_digits - wrap to four digits and split into segment codes
// Three stages: modulo 10000, thousands and hundreds, tens and units.
// ----------------------------------------------------------------------------
module asd_digits (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  asd_pkg::quot_t  in_item,
  output logic            out_valid,
  input  logic            out_stall,
  output asd_pkg::disp_t  out_disp
);
  import asd_pkg::*;

  logic              v4_r, v5_r, v6_r;
  logic              s4, s5, s6;
  logic [QUOT_W-1:0] wrapped;
  logic [NUM_W-1:0]  n4_r;
  places_t           pl4_r, pl5_r;
  logic [3:0]        th, hu, te, un;
  logic [NUM_W-1:0]  r1_full;
  logic [9:0]        r1;
  logic [9:0]        r2_full;
  logic [6:0]        r2;
  logic [6:0]        r3_full;
  logic [3:0]        th5_r, hu5_r;
  logic [6:0]        r2_5_r;
  disp_t             disp_nxt, disp6_r;

  assign s6       = v6_r & out_stall;
  assign s5       = v5_r & s6;
  assign s4       = v4_r & s5;
  assign in_stall = s4;

  // quotient stays below twice 10000, so one subtract wraps it
  assign wrapped = (in_item.q >= WRAP) ? in_item.q - WRAP : in_item.q;

  always_comb begin
    th      = digit_of(n4_r, 10'd1000);
    r1_full = n4_r - 14'(th) * 14'd1000;
    r1      = r1_full[9:0];
    hu      = digit_of({4'd0, r1}, 10'd100);
    r2_full = r1 - 10'(hu) * 10'd100;
    r2      = r2_full[6:0];
  end

  always_comb begin
    te       = digit_of({7'd0, r2_5_r}, 10'd10);
    r3_full  = r2_5_r - 7'(te) * 7'd10;
    un       = r3_full[3:0];
    disp_nxt.seg[0]  = seg_code(th5_r);
    disp_nxt.seg[1]  = seg_code(hu5_r);
    disp_nxt.seg[2]  = seg_code(te);
    disp_nxt.seg[3]  = seg_code(un);
    disp_nxt.dp_mask = dp_of(pl5_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (!s4) v4_r <= in_valid;
      if (!s5) v5_r <= v4_r;
      if (!s6) v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!s4) begin
      n4_r  <= wrapped[NUM_W-1:0];
      pl4_r <= in_item.places;
    end
    if (!s5) begin
      th5_r  <= th;
      hu5_r  <= hu;
      r2_5_r <= r2;
      pl5_r  <= pl4_r;
    end
    if (!s6) disp6_r <= disp_nxt;
  end

  assign out_valid = v6_r;
  assign out_disp  = disp6_r;

endmodule

/* rtl/core/asd_scan.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asd_scan - digit scan serializer
// Holds one four-digit request and sends it as four digit results, left to
// right; loads the next request as the last digit leaves.
// ----------------------------------------------------------------------------
module asd_scan (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  asd_pkg::disp_t              in_disp,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [asd_pkg::DIGITS-1:0]  out_digit_select_n,
  output logic [asd_pkg::SEG_W-1:0]   out_segments,
  output logic                        out_decimal_point,
  output logic                        out_last_digit
);
  import asd_pkg::*;

  logic        busy_r;
  logic [1:0]  cnt_r;
  disp_t       disp_r;
  logic        last;
  logic        done;
  logic        load;

  assign last     = (cnt_r == 2'd3);
  assign done     = busy_r & ~out_stall & last;
  assign in_stall = busy_r & ~done;
  assign load     = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else if (load) begin
      busy_r <= 1'b1;
      cnt_r  <= 2'd0;
    end else if (busy_r && !out_stall) begin
      if (last) busy_r <= 1'b0;
      cnt_r <= cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) disp_r <= in_disp;
  end

  assign out_valid          = busy_r;
  assign out_digit_select_n = ~(4'b0001 << cnt_r);
  assign out_segments       = disp_r.seg[cnt_r];
  assign out_decimal_point  = disp_r.dp_mask[cnt_r];
  assign out_last_digit     = last;

endmodule

/* rtl/core/autorange_four_digit_segment_drive.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// autorange_four_digit_segment_drive - auto-ranging four-digit display driver
// Scales a value in thousandths to four rounded digits and scans them out as
// per-digit select, segment and decimal point results.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_value_milli): one request is a
//   value in thousandths. The block shows 3, 2, 1 or 0 decimal places as the
//   value is below 10, 100, 1000 or beyond, rounding half up; a rounded
//   value of 10000 or more keeps only its low four digits.
//   Result channel (out_valid / out_stall / out_*): each request yields four
//   results, leftmost digit first, with the active-low digit select, the
//   a..g pattern, the decimal point, and last_digit on the fourth.
//   The first digit of a request is valid after the request enters stage 1
//   at the accepting edge, advances through stages 2 to 6 and loads the
//   scan register.
//   Throughput: set by the single result port, one digit per cycle while
//   out_stall is low; the six pipeline stages take a new request every
//   cycle unless stalled and queue up to six behind the scan register.
//   Reset (rst_n low, synchronous) empties every stage; no results follow.
//   When the receiver stalls, the current digit holds, the pipeline fills
//   behind it and in_stall rises once every stage is occupied.
// ----------------------------------------------------------------------------
module autorange_four_digit_segment_drive (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [asd_pkg::VALUE_W-1:0] in_value_milli,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [asd_pkg::DIGITS-1:0]  out_digit_select_n,
  output logic [asd_pkg::SEG_W-1:0]   out_segments,
  output logic                        out_decimal_point,
  output logic                        out_last_digit
);
  import asd_pkg::*;

  // range/divide section to digit section
  logic  q_valid;
  logic  q_stall;
  quot_t q_item;

  // digit section to scan register
  logic  d_valid;
  logic  d_stall;
  disp_t d_disp;

  // stages 1..3: place select with rounding, reciprocal multiply, correction
  asd_range_div u_range_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_value  (in_value_milli),
    .out_valid (q_valid),
    .out_stall (q_stall),
    .out_item  (q_item)
  );

  // stages 4..6: wrap to four digits, split digits, look up segments
  asd_digits u_digits (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (q_valid),
    .in_stall  (q_stall),
    .in_item   (q_item),
    .out_valid (d_valid),
    .out_stall (d_stall),
    .out_disp  (d_disp)
  );

  // scan out one digit per cycle while out_stall is low, left to right
  asd_scan u_scan (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (d_valid),
    .in_stall           (d_stall),
    .in_disp            (d_disp),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_digit_select_n (out_digit_select_n),
    .out_segments       (out_segments),
    .out_decimal_point  (out_decimal_point),
    .out_last_digit     (out_last_digit)
  );

endmodule

/* tb/sv/tb_autorange_four_digit_segment_drive.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_autorange_four_digit_segment_drive - digit scan check of the segment drive
// Feeds values in thousandths, predicts the rounded, auto-ranged four-digit
// readout and compares every digit result (select, segments, point, last
// flag) in order, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_autorange_four_digit_segment_drive;

  import asd_pkg::*;

  localparam int unsigned QUIET_LIMIT = 3000;
  localparam int unsigned RANDOM_PER_PHASE = 135;
  localparam int unsigned REPORT_LIMIT = 10;

  // One digit result as it leaves the block.
  typedef struct packed {
    logic [DIGITS-1:0] sel_n;
    logic [SEG_W-1:0]  seg;
    logic              dp;
    logic              last;
  } digit_res_t;

  // One request of the stimulus. With typed set, the readout is given here
  // (shown integer and places) instead of being worked out by the predictor.
  typedef struct {
    logic [VALUE_W-1:0] value;
    bit                 typed;
    int unsigned        shown;
    places_t            places;
  } row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [VALUE_W-1:0]   in_value_milli;
  logic                 out_valid;
  logic                 out_stall;
  logic [DIGITS-1:0]    out_digit_select_n;
  logic [SEG_W-1:0]     out_segments;
  logic                 out_decimal_point;
  logic                 out_last_digit;

  row_t         offered_rows[$];
  digit_res_t   pending_digits[$];
  int unsigned  requests_taken = 0;
  int unsigned  quiet_cycles = 0;
  int unsigned  mismatches = 0;
  int unsigned  tx_idle_pct = 0;
  int unsigned  rx_stall_pct = 0;

  // Directed requests: range edges, rounding half up and down, wrap of the
  // rounded value to 0000 in each range that rounds, the top of range and the 24-bit max.
  row_t directed_rows [25] = '{
    '{24'd0,        1'b1, 0,    PLACES_3},
    '{24'd9999,     1'b1, 9999, PLACES_3},
    '{24'd1234,     1'b1, 1234, PLACES_3},
    '{24'd5678,     1'b1, 5678, PLACES_3},
    '{24'd10000,    1'b1, 1000, PLACES_2},
    '{24'd12344,    1'b1, 1234, PLACES_2},
    '{24'd12345,    1'b1, 1235, PLACES_2},
    '{24'd99994,    1'b1, 9999, PLACES_2},
    '{24'd99995,    1'b1, 0,    PLACES_2},
    '{24'd100000,   1'b1, 1000, PLACES_1},
    '{24'd999949,   1'b1, 9999, PLACES_1},
    '{24'd999950,   1'b1, 0,    PLACES_1},
    '{24'd1000000,  1'b1, 1000, PLACES_0},
    '{24'd9999499,  1'b1, 9999, PLACES_0},
    '{24'd9999500,  1'b1, 0,    PLACES_0},
    '{24'd9999999,  1'b1, 0,    PLACES_0},
    '{24'd10000000, 1'b1, 0,    PLACES_0},
    '{24'hFFFFFF,   1'b1, 6777, PLACES_0},
    '{24'd10005,    1'b0, 0,    PLACES_0},
    '{24'd123456,   1'b0, 0,    PLACES_0},
    '{24'd5000500,  1'b0, 0,    PLACES_0},
    '{24'd4321987,  1'b0, 0,    PLACES_0},
    '{24'd9,        1'b0, 0,    PLACES_0},
    '{24'd99999,    1'b0, 0,    PLACES_0},
    '{24'd8765432,  1'b0, 0,    PLACES_0}
  };

  autorange_four_digit_segment_drive dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_value_milli     (in_value_milli),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_digit_select_n (out_digit_select_n),
    .out_segments       (out_segments),
    .out_decimal_point  (out_decimal_point),
    .out_last_digit     (out_last_digit)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // a..g pattern of one decimal digit, bit0 = a
  function automatic logic [SEG_W-1:0] segments_for(int unsigned d);
    logic [SEG_W-1:0] s;
    case (d)
      0:       s = 7'h3F;
      1:       s = 7'h06;
      2:       s = 7'h5B;
      3:       s = 7'h4F;
      4:       s = 7'h66;
      5:       s = 7'h6D;
      6:       s = 7'h7D;
      7:       s = 7'h07;
      8:       s = 7'h7F;
      default: s = 7'h6F;
    endcase
    return s;
  endfunction

  // Pick the places from the magnitude, round half up to them and keep the
  // low four digits of the result.
  function automatic void round_for_display(input logic [VALUE_W-1:0] v,
                                            output int unsigned shown,
                                            output places_t places);
    int unsigned w;
    int unsigned n;
    w = v;
    if (w < 10000) begin
      places = PLACES_3;
      n = w;
    end else if (w < 100000) begin
      places = PLACES_2;
      n = (w + 5) / 10;
    end else if (w < 1000000) begin
      places = PLACES_1;
      n = (w + 50) / 100;
    end else begin
      places = PLACES_0;
      n = (w + 500) / 1000;
    end
    shown = n % 10000;
  endfunction

  // Queue the four digit results of one readout, leftmost first. The point
  // goes on digit index 3 - places; none with zero places.
  function automatic void push_readout(int unsigned shown, places_t places);
    digit_res_t  r;
    int unsigned scale;
    scale = 1000;
    for (int i = 0; i < DIGITS; i++) begin
      r.sel_n = ~(4'b0001 << i);
      r.seg   = segments_for((shown / scale) % 10);
      r.dp    = (places != PLACES_0) && (3 - int'(places) == i);
      r.last  = (i == DIGITS - 1);
      pending_digits.push_back(r);
      scale = scale / 10;
    end
  endfunction

  // Random value, weighted toward range edges and rounding ties.
  function automatic logic [VALUE_W-1:0] random_value();
    int unsigned kind;
    int unsigned unit;
    int unsigned base;
    int unsigned edge_at;
    kind = $urandom_range(9);
    case (kind)
      0: return VALUE_W'($urandom_range(9999));
      1: return VALUE_W'($urandom_range(99999, 10000));
      2: return VALUE_W'($urandom_range(999999, 100000));
      3: return VALUE_W'($urandom_range(9999999, 1000000));
      4: return VALUE_W'($urandom_range(24'hFFFFFF, 10000000));
      5: begin
        // land on a rounding tie or just under it
        case ($urandom_range(2))
          0:       unit = 10;
          1:       unit = 100;
          default: unit = 1000;
        endcase
        base = $urandom_range(16000000, 10000);
        return VALUE_W'(base - base % unit + unit / 2 - $urandom_range(1));
      end
      6: begin
        // straddle a range limit
        case ($urandom_range(3))
          0:       edge_at = 10000;
          1:       edge_at = 100000;
          2:       edge_at = 1000000;
          default: edge_at = 10000000;
        endcase
        return VALUE_W'(edge_at + $urandom_range(20) - 10);
      end
      7: begin
        // straddle the point where rounding wraps to 0000
        case ($urandom_range(2))
          0:       edge_at = 99995;
          1:       edge_at = 999950;
          default: edge_at = 9999500;
        endcase
        return VALUE_W'(edge_at + $urandom_range(6) - 3);
      end
      default: return VALUE_W'($urandom);
    endcase
  endfunction

  // Offer one request: idle at random first, then hold valid and the value
  // until the request is taken. Returns at the falling edge after the accept.
  task automatic offer_request(input row_t row);
    int unsigned taken_before;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    offered_rows.push_back(row);
    in_valid       <= 1'b1;
    in_value_milli <= row.value;
    taken_before = requests_taken;
    do @(negedge clk); while (requests_taken == taken_before);
  endtask

  // Receiver: stall at random at the falling edge; never during reset.
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < rx_stall_pct);
  end

  // Monitor both channels at the rising edge. Predict on every taken request,
  // check every taken digit against the oldest expectation.
  always @(posedge clk) begin
    row_t        row;
    digit_res_t  got;
    digit_res_t  want;
    int unsigned shown;
    places_t     places;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        requests_taken++;
        row = offered_rows.pop_front();
        if (row.typed) begin
          push_readout(row.shown, row.places);
        end else begin
          round_for_display(row.value, shown, places);
          push_readout(shown, places);
        end
      end
      if (out_valid && !out_stall) begin
        got = '{out_digit_select_n, out_segments, out_decimal_point, out_last_digit};
        if (pending_digits.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: digit result with nothing pending: sel_n=%b seg=%h dp=%b last=%b",
                     $realtime, got.sel_n, got.seg, got.dp, got.last);
        end else begin
          want = pending_digits.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("%0t: digit mismatch: sel_n=%b/%b seg=%h/%h dp=%b/%b last=%b/%b (exp/got)",
                       $realtime, want.sel_n, got.sel_n, want.seg, got.seg,
                       want.dp, got.dp, want.last, got.last);
          end
        end
      end
      // count cycles in which neither channel moves
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  // Watchdog: end the run once nothing has moved for too long.
  initial begin
    do @(negedge clk); while (quiet_cycles < QUIET_LIMIT);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    row_t row;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_value_milli <= '0;
    out_stall      <= 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part under the first idling mix
    tx_idle_pct  = 35;
    rx_stall_pct = 54;
    foreach (directed_rows[i]) offer_request(directed_rows[i]);

    // random part: receiver-heavy stalling, then sender-heavy idling, then none
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin tx_idle_pct = 35; rx_stall_pct = 54; end
        1:       begin tx_idle_pct = 54; rx_stall_pct = 35; end
        default: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
      endcase
      for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
        row.value  = random_value();
        row.typed  = 1'b0;
        row.shown  = 0;
        row.places = PLACES_0;
        offer_request(row);
      end
    end
    in_valid <= 1'b0;

    // drain, then let stray results show up past the pipeline depth
    while (pending_digits.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    if (mismatches == 0 && pending_digits.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
